// ===== sv/efd_pkg.sv =====
// Shared types, codes and reset values of the EMG repetition fatigue detector.
package efd_pkg;

	typedef enum logic [0:0] {
		OP_SAMPLE = 1'b0,
		OP_START  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		FAIL_NONE  = 2'd0,
		FAIL_WEAK  = 2'd1,
		FAIL_SHORT = 2'd2
	} fail_t;

	localparam int CfgIdxBits  = 3;
	localparam int CfgDataBits = 16;

	localparam logic [CfgIdxBits-1:0] REG_START_THR    = 3'd0;
	localparam logic [CfgIdxBits-1:0] REG_END_THR      = 3'd1;
	localparam logic [CfgIdxBits-1:0] REG_MIN_REPS     = 3'd2;
	localparam logic [CfgIdxBits-1:0] REG_MIN_VALID    = 3'd3;
	localparam logic [CfgIdxBits-1:0] REG_MAX_SHORT    = 3'd4;
	localparam logic [CfgIdxBits-1:0] REG_FAIL_PERCENT = 3'd5;
	localparam logic [CfgIdxBits-1:0] REG_SHORT_NEEDED = 3'd6;
	localparam logic [CfgIdxBits-1:0] REG_SHORT_WINDOW = 3'd7;

	localparam int RstStartThr     = 200;
	localparam int RstEndThr       = 100;
	localparam logic [7:0]  RST_MIN_REPS     = 8'd3;
	localparam logic [15:0] RST_MIN_VALID    = 16'd50;
	localparam logic [15:0] RST_MAX_SHORT    = 16'd50;
	localparam logic [6:0]  RST_FAIL_PERCENT = 7'd60;
	localparam logic [7:0]  RST_SHORT_NEEDED = 8'd3;
	localparam logic [15:0] RST_SHORT_WINDOW = 16'd1000;

	localparam logic [6:0] PERCENT_FULL = 7'd100;

	typedef struct packed {
		logic [7:0]  min_reps;
		logic [15:0] min_valid;
		logic [15:0] max_short;
		logic [6:0]  fail_percent;
		logic [7:0]  short_needed;
		logic [15:0] short_window;
	} cfg_t;

endpackage

// ===== sv/efd_cfg_regs.sv =====
// Configuration register file of the EMG repetition fatigue detector.
module efd_cfg_regs #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [efd_pkg::CfgIdxBits-1:0]   wr_index,
	input  logic [efd_pkg::CfgDataBits-1:0]  wr_data,
	output logic [SAMPLE_BITS-1:0]           start_thr,
	output logic [SAMPLE_BITS-1:0]           end_thr,
	output efd_pkg::cfg_t                    cfg
);
	import efd_pkg::*;

	logic [SAMPLE_BITS-1:0] start_thr_q;
	logic [SAMPLE_BITS-1:0] end_thr_q;
	cfg_t                   cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_thr_q         <= SAMPLE_BITS'(RstStartThr);
			end_thr_q           <= SAMPLE_BITS'(RstEndThr);
			cfg_q.min_reps      <= RST_MIN_REPS;
			cfg_q.min_valid     <= RST_MIN_VALID;
			cfg_q.max_short     <= RST_MAX_SHORT;
			cfg_q.fail_percent  <= RST_FAIL_PERCENT;
			cfg_q.short_needed  <= RST_SHORT_NEEDED;
			cfg_q.short_window  <= RST_SHORT_WINDOW;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_START_THR:    start_thr_q        <= wr_data[SAMPLE_BITS-1:0];
				REG_END_THR:      end_thr_q          <= wr_data[SAMPLE_BITS-1:0];
				REG_MIN_REPS:     cfg_q.min_reps     <= wr_data[7:0];
				REG_MIN_VALID:    cfg_q.min_valid    <= wr_data;
				REG_MAX_SHORT:    cfg_q.max_short    <= wr_data;
				REG_FAIL_PERCENT: cfg_q.fail_percent <= wr_data[6:0];
				REG_SHORT_NEEDED: cfg_q.short_needed <= wr_data[7:0];
				REG_SHORT_WINDOW: cfg_q.short_window <= wr_data;
				default: ;
			endcase
		end
	end

	assign start_thr = start_thr_q;
	assign end_thr   = end_thr_q;
	assign cfg       = cfg_q;

endmodule

// ===== sv/efd_core.sv =====
// Repetition tracking state and the combinational update for one request.
module efd_core #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  efd_pkg::opcode_t        opcode,
	input  logic [SAMPLE_BITS-1:0]  sample,
	input  logic [SAMPLE_BITS-1:0]  start_thr,
	input  logic [SAMPLE_BITS-1:0]  end_thr,
	input  efd_pkg::cfg_t           cfg,
	output logic                    rep_done,
	output logic [SAMPLE_BITS-1:0]  rep_peak,
	output logic [15:0]             rep_total,
	output logic [SAMPLE_BITS-1:0]  highest_seen,
	output efd_pkg::fail_t          failure_kind,
	output logic                    recording,
	output logic                    inside_rep
);
	import efd_pkg::*;

	localparam int ProdBits = SAMPLE_BITS + 7;

	logic                   rec_q, rec_n;
	logic                   open_q, open_n;
	logic [SAMPLE_BITS-1:0] peak_now_q, peak_now_n;
	logic [15:0]            rep_len_q, rep_len_n;
	logic [15:0]            valid_reps_q, valid_reps_n;
	logic [SAMPLE_BITS-1:0] peak_max_q, peak_max_n;
	logic [7:0]             short_cnt_q, short_cnt_n;
	logic [15:0]            last_valid_q, last_valid_n;
	logic [15:0]            clock_q, clock_n;
	fail_t                  fail_q, fail_n;
	logic                   done;

	logic [SAMPLE_BITS-1:0] peak_upd;
	logic [SAMPLE_BITS-1:0] pmax_upd;
	logic [15:0]            len_upd;
	logic [15:0]            vreps_upd;
	logic [7:0]             scnt_upd;
	logic [ProdBits-1:0]    peak_scaled;
	logic [ProdBits-1:0]    limit_scaled;
	logic [15:0]            since_valid;

	assign peak_upd     = (sample > peak_now_q) ? sample : peak_now_q;
	assign pmax_upd     = (peak_upd > peak_max_q) ? peak_upd : peak_max_q;
	assign len_upd      = (rep_len_q != 16'hFFFF) ? rep_len_q + 16'd1 : rep_len_q;
	assign vreps_upd    = (valid_reps_q != 16'hFFFF) ? valid_reps_q + 16'd1 : valid_reps_q;
	assign scnt_upd     = (short_cnt_q != 8'hFF) ? short_cnt_q + 8'd1 : short_cnt_q;
	assign peak_scaled  = ProdBits'(peak_upd) * ProdBits'(PERCENT_FULL);
	assign limit_scaled = ProdBits'(cfg.fail_percent) * ProdBits'(pmax_upd);
	assign since_valid  = clock_q - last_valid_q;

	always_comb begin
		rec_n        = rec_q;
		open_n       = open_q;
		peak_now_n   = peak_now_q;
		rep_len_n    = rep_len_q;
		valid_reps_n = valid_reps_q;
		peak_max_n   = peak_max_q;
		short_cnt_n  = short_cnt_q;
		last_valid_n = last_valid_q;
		clock_n      = clock_q;
		fail_n       = fail_q;
		done         = 1'b0;
		if (opcode == OP_START) begin
			if (!rec_q && fail_q == FAIL_NONE) begin
				rec_n        = 1'b1;
				clock_n      = '0;
				open_n       = 1'b0;
				valid_reps_n = '0;
				short_cnt_n  = '0;
				peak_max_n   = '0;
				last_valid_n = '0;
			end
		end else if (rec_q && fail_q == FAIL_NONE) begin
			clock_n = clock_q + 16'd1;
			if (!open_q) begin
				if (sample > start_thr) begin
					open_n     = 1'b1;
					peak_now_n = sample;
					rep_len_n  = '0;
				end
			end else begin
				rep_len_n  = len_upd;
				peak_now_n = peak_upd;
				if (sample < end_thr) begin
					open_n = 1'b0;
					if (len_upd >= cfg.min_valid) begin
						done         = 1'b1;
						valid_reps_n = vreps_upd;
						peak_max_n   = pmax_upd;
						last_valid_n = clock_q;
						short_cnt_n  = '0;
						if (vreps_upd >= 16'(cfg.min_reps) && pmax_upd != '0 &&
						    peak_scaled < limit_scaled) begin
							fail_n = FAIL_WEAK;
							rec_n  = 1'b0;
						end
					end else if (len_upd <= cfg.max_short) begin
						short_cnt_n = scnt_upd;
						if (valid_reps_q >= 16'(cfg.min_reps) &&
						    scnt_upd >= cfg.short_needed &&
						    since_valid < cfg.short_window) begin
							fail_n = FAIL_SHORT;
							rec_n  = 1'b0;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q        <= 1'b0;
			open_q       <= 1'b0;
			peak_now_q   <= '0;
			rep_len_q    <= '0;
			valid_reps_q <= '0;
			peak_max_q   <= '0;
			short_cnt_q  <= '0;
			last_valid_q <= '0;
			clock_q      <= '0;
			fail_q       <= FAIL_NONE;
		end else if (step) begin
			rec_q        <= rec_n;
			open_q       <= open_n;
			peak_now_q   <= peak_now_n;
			rep_len_q    <= rep_len_n;
			valid_reps_q <= valid_reps_n;
			peak_max_q   <= peak_max_n;
			short_cnt_q  <= short_cnt_n;
			last_valid_q <= last_valid_n;
			clock_q      <= clock_n;
			fail_q       <= fail_n;
		end
	end

	assign rep_done     = done;
	assign rep_peak     = peak_now_n;
	assign rep_total    = valid_reps_n;
	assign highest_seen = peak_max_n;
	assign failure_kind = fail_n;
	assign recording    = rec_n;
	assign inside_rep   = open_n;

endmodule

// ===== sv/emg_rep_fatigue_detector.sv =====
// Top level of the EMG repetition fatigue detector: stream ports, input and result registers.
// The block takes one request per clock cycle while the result side keeps up and gives one result
// per request. An accepted request is held in the input register, goes through the combinational
// repetition update and is loaded into the result register once the result register is free; the
// input register holds it while the result side stalls, so requests follow back to back at a
// sustained rate of one per cycle whenever the result side keeps taking results. A
// start command begins recording, samples then drive the repetition detector, and a declared
// failure stops recording until reset. Configuration registers are written through the cfg
// channel, which is always ready; they should be changed only while no request is in flight.
module emg_rep_fatigue_detector #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// sample
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
	// opcode
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// rep_done, rep_peak, rep_total, highest_seen, failure_kind, recording, inside_rep
	output logic [((2*SAMPLE_BITS+21+7)/8)*8-1:0] m_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [efd_pkg::CfgIdxBits-1:0]       cfg_index,
	input  logic [efd_pkg::CfgDataBits-1:0]      cfg_data
);
	import efd_pkg::*;

	localparam int OutBits  = 2*SAMPLE_BITS + 21;
	localparam int OutBytes = ((OutBits + 7) / 8) * 8;

	logic                   valid_s1;
	opcode_t                opcode_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   out_valid_q;
	logic [OutBits-1:0]     result_q;
	logic                   out_free;
	logic                   advance;
	logic                   in_accept;

	logic [SAMPLE_BITS-1:0] start_thr;
	logic [SAMPLE_BITS-1:0] end_thr;
	cfg_t                   cfg;

	logic                   rep_done;
	logic [SAMPLE_BITS-1:0] rep_peak;
	logic [15:0]            rep_total;
	logic [SAMPLE_BITS-1:0] highest_seen;
	fail_t                  failure_kind;
	logic                   recording;
	logic                   inside_rep;

	assign out_free  = !out_valid_q || m_tready;
	assign advance   = valid_s1 && out_free;
	assign s_tready  = !valid_s1 || out_free;
	assign in_accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	efd_cfg_regs #(.SAMPLE_BITS(SAMPLE_BITS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (cfg_valid && cfg_ready),
		.wr_index  (cfg_index),
		.wr_data   (cfg_data),
		.start_thr (start_thr),
		.end_thr   (end_thr),
		.cfg       (cfg)
	);

	efd_core #(.SAMPLE_BITS(SAMPLE_BITS)) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.opcode       (opcode_s1),
		.sample       (sample_s1),
		.start_thr    (start_thr),
		.end_thr      (end_thr),
		.cfg          (cfg),
		.rep_done     (rep_done),
		.rep_peak     (rep_peak),
		.rep_total    (rep_total),
		.highest_seen (highest_seen),
		.failure_kind (failure_kind),
		.recording    (recording),
		.inside_rep   (inside_rep)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			opcode_s1 <= opcode_t'(s_tuser);
			sample_s1 <= s_tdata[SAMPLE_BITS-1:0];
		end
		if (advance) begin
			result_q <= {inside_rep, recording, failure_kind, highest_seen, rep_total,
			             rep_peak, rep_done};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OutBytes - OutBits)'(0), result_q};

	ap_fail_stops_recording: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && result_q[OutBits-3 -: 2] != FAIL_NONE |-> !result_q[OutBits-2])
		else $error("failure reported while still recording");

	ap_done_closes_rep: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && result_q[0] |-> !result_q[OutBits-1])
		else $error("counted repetition reported while a repetition is still open");

	ap_result_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s1))
		else $error("result appeared without a request in the input register");

	ap_input_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(sample_s1))
		else $error("stalled request lost from the input register");

endmodule

// ===== sim/efd_checker.sv =====
// Result checker for the EMG repetition fatigue detector: watches the channels, predicts and compares.
module efd_checker #(
	parameter int SAMPLE_BITS = 12,
	parameter int IN_W        = 16,
	parameter int OUT_W       = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [IN_W-1:0]                 s_tdata,
	input  logic                            s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [OUT_W-1:0]                m_tdata,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [efd_pkg::CfgIdxBits-1:0]  cfg_index,
	input  logic [efd_pkg::CfgDataBits-1:0] cfg_data,
	output int                              mismatches,
	output int                              due_count
);
	import efd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                   inside_rep;
		logic                   recording;
		fail_t                  failure_kind;
		logic [SAMPLE_BITS-1:0] highest_seen;
		logic [15:0]            rep_total;
		logic [SAMPLE_BITS-1:0] rep_peak;
		logic                   rep_done;
	} rep_status_t;

	localparam int StatusBits = $bits(rep_status_t);
	localparam int PrintCap   = 200;

	logic [SAMPLE_BITS-1:0] thr_open, thr_close;
	logic [7:0]             reps_before_fail, shorts_to_fail;
	logic [15:0]            valid_len, short_len, short_span;
	logic [6:0]             weak_pct;

	logic                   rec_on, rep_active;
	logic [SAMPLE_BITS-1:0] cur_peak, best_peak;
	logic [15:0]            cur_len, reps_valid, last_valid_at, tick;
	logic [7:0]             shorts_seen;
	fail_t                  fail_q;

	rep_status_t status_due[$];
	rep_status_t got, want;
	int          errs = 0;
	int          printed = 0;

	function automatic rep_status_t next_rep_status(opcode_t op, logic [SAMPLE_BITS-1:0] smp);
		rep_status_t res;
		logic [15:0] since_valid;
		logic        done;
		done = 1'b0;
		if (op == OP_START) begin
			if (!rec_on && fail_q == FAIL_NONE) begin
				rec_on = 1'b1;
				tick = '0;
				rep_active = 1'b0;
				reps_valid = '0;
				shorts_seen = '0;
				best_peak = '0;
				last_valid_at = '0;
			end
		end else if (rec_on && fail_q == FAIL_NONE) begin
			if (!rep_active) begin
				if (smp > thr_open) begin
					rep_active = 1'b1;
					cur_peak = smp;
					cur_len = '0;
				end
			end else begin
				if (cur_len != '1)
					cur_len++;
				if (smp > cur_peak)
					cur_peak = smp;
				if (smp < thr_close) begin
					rep_active = 1'b0;
					if (cur_len >= valid_len) begin
						done = 1'b1;
						if (reps_valid != '1)
							reps_valid++;
						if (cur_peak > best_peak)
							best_peak = cur_peak;
						last_valid_at = tick;
						shorts_seen = '0;
						if (reps_valid >= reps_before_fail && best_peak != '0 &&
								32'(cur_peak) * 32'(PERCENT_FULL) < 32'(weak_pct) * 32'(best_peak)) begin
							fail_q = FAIL_WEAK;
							rec_on = 1'b0;
						end
					end else if (cur_len <= short_len) begin
						if (shorts_seen != '1)
							shorts_seen++;
						since_valid = tick - last_valid_at;
						if (reps_valid >= reps_before_fail && shorts_seen >= shorts_to_fail &&
								since_valid < short_span) begin
							fail_q = FAIL_SHORT;
							rec_on = 1'b0;
						end
					end
				end
			end
			tick = tick + 16'd1;
		end
		res.rep_done = done;
		res.rep_peak = cur_peak;
		res.rep_total = reps_valid;
		res.highest_seen = best_peak;
		res.failure_kind = fail_q;
		res.recording = rec_on;
		res.inside_rep = rep_active;
		return res;
	endfunction

	task automatic compare_field(string field, int unsigned expected, int unsigned actual);
		if (expected != actual) begin
			errs++;
			if (printed < PrintCap) begin
				printed++;
				$display("%0t: %s expected %0d, got %0d", $time, field, expected, actual);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_open = SAMPLE_BITS'(RstStartThr);
			thr_close = SAMPLE_BITS'(RstEndThr);
			reps_before_fail = RST_MIN_REPS;
			valid_len = RST_MIN_VALID;
			short_len = RST_MAX_SHORT;
			weak_pct = RST_FAIL_PERCENT;
			shorts_to_fail = RST_SHORT_NEEDED;
			short_span = RST_SHORT_WINDOW;
			rec_on = 1'b0;
			rep_active = 1'b0;
			cur_peak = '0;
			best_peak = '0;
			cur_len = '0;
			reps_valid = '0;
			last_valid_at = '0;
			tick = '0;
			shorts_seen = '0;
			fail_q = FAIL_NONE;
			status_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_START_THR:    thr_open = cfg_data[SAMPLE_BITS-1:0];
					REG_END_THR:      thr_close = cfg_data[SAMPLE_BITS-1:0];
					REG_MIN_REPS:     reps_before_fail = cfg_data[7:0];
					REG_MIN_VALID:    valid_len = cfg_data[15:0];
					REG_MAX_SHORT:    short_len = cfg_data[15:0];
					REG_FAIL_PERCENT: weak_pct = cfg_data[6:0];
					REG_SHORT_NEEDED: shorts_to_fail = cfg_data[7:0];
					REG_SHORT_WINDOW: short_span = cfg_data[15:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = rep_status_t'(m_tdata[StatusBits-1:0]);
				if (status_due.size() == 0) begin
					errs++;
					if (printed < PrintCap) begin
						printed++;
						$display("%0t: result with no request outstanding, expected none, got %h",
							$time, m_tdata);
					end
				end else begin
					want = status_due.pop_front();
					compare_field("rep_done", want.rep_done, got.rep_done);
					compare_field("rep_peak", want.rep_peak, got.rep_peak);
					compare_field("rep_total", want.rep_total, got.rep_total);
					compare_field("highest_seen", want.highest_seen, got.highest_seen);
					compare_field("failure_kind", want.failure_kind, got.failure_kind);
					compare_field("recording", want.recording, got.recording);
					compare_field("inside_rep", want.inside_rep, got.inside_rep);
				end
			end
			if (s_tvalid && s_tready)
				status_due.push_back(next_rep_status(opcode_t'(s_tuser),
					s_tdata[SAMPLE_BITS-1:0]));
		end
		mismatches <= errs;
		due_count <= status_due.size();
	end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the EMG repetition fatigue detector: clock, reset, stimulus and verdict.
module tb;
	import efd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SB        = 12;
	localparam int IN_W      = ((SB + 7) / 8) * 8;
	localparam int OUT_W     = ((2 * SB + 21 + 7) / 8) * 8;
	localparam int MaxSample = (1 << SB) - 1;
	localparam int CycleLimit = 300000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_W-1:0]        s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_W-1:0]       m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CfgIdxBits-1:0]  cfg_index = '0;
	logic [CfgDataBits-1:0] cfg_data = '0;

	int mismatches;
	int due_count;
	int cycles = 0;
	int burst_left = 0;
	int items_sent = 0;
	int ready_left = 0;
	bit ready_on = 1'b0;

	int cur_st = RstStartThr;
	int cur_et = RstEndThr;
	int cur_vlen = RST_MIN_VALID;
	int cur_slen = RST_MAX_SHORT;

	always #5 clk = ~clk;

	emg_rep_fatigue_detector #(.SAMPLE_BITS(SB)) dut (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	efd_checker #(.SAMPLE_BITS(SB), .IN_W(IN_W), .OUT_W(OUT_W)) chk (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.mismatches, .due_count
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	// The result side alternates runs of readiness, some of them long, with short stalls.
	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_on = !ready_on;
			if (ready_on)
				ready_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
					: $urandom_range(1, 12);
			else
				ready_left = $urandom_range(1, 5);
			m_tready <= ready_on;
		end else begin
			ready_left--;
		end
	end

	function automatic int span(int lo, int hi);
		return (hi <= lo) ? lo : int'($urandom_range(lo, hi));
	endfunction

	task automatic send_req(opcode_t op, int smp);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
				: $urandom_range(1, 16);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= IN_W'(smp);
		do @(posedge clk); while (!s_tready);
		burst_left--;
		items_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (due_count != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxBits-1:0] idx, int val, int bits, bit junk);
		logic [CfgDataBits-1:0] word;
		word = CfgDataBits'(val);
		if (junk && bits < CfgDataBits)
			word = word | (CfgDataBits'($urandom) << bits);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= word;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(int st, int et, int reps, int vlen, int slen, int pct, int shorts,
			int win, bit junk);
		write_reg(REG_START_THR, st, SB, junk);
		write_reg(REG_END_THR, et, SB, junk);
		write_reg(REG_MIN_REPS, reps, 8, junk);
		write_reg(REG_MIN_VALID, vlen, 16, junk);
		write_reg(REG_MAX_SHORT, slen, 16, junk);
		write_reg(REG_FAIL_PERCENT, pct, 7, junk);
		write_reg(REG_SHORT_NEEDED, shorts, 8, junk);
		write_reg(REG_SHORT_WINDOW, win, 16, junk);
		cfg_valid <= 1'b0;
		cur_st = st;
		cur_et = et;
		cur_vlen = vlen;
		cur_slen = slen;
	endtask

	// A well-formed repetition: one opening sample, a body that stays at or above the closing
	// level and one closing sample, with a length aimed around the valid and short limits.
	task automatic send_rep();
		int top;
		int target;
		int lo;
		if (cur_st >= MaxSample) begin
			send_req(OP_SAMPLE, $urandom_range(0, MaxSample));
			return;
		end
		top = $urandom_range(cur_st + 1, MaxSample);
		send_req(OP_SAMPLE, $urandom_range(cur_st + 1, top));
		lo = (cur_vlen > 2) ? cur_vlen - 2 : 1;
		case ($urandom_range(0, 4))
			0, 1: target = $urandom_range(lo, lo + 4);
			2, 3: target = $urandom_range(1, cur_slen + 1);
			default: target = $urandom_range(1, 16);
		endcase
		if (target > 24)
			target = $urandom_range(1, 24);
		repeat (target - 1) send_req(OP_SAMPLE, span(cur_et, top));
		if (cur_et > 0)
			send_req(OP_SAMPLE, $urandom_range(0, cur_et - 1));
	endtask

	task automatic run_phase(int n);
		int stop;
		int pick;
		stop = items_sent + n;
		while (items_sent < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 60)
				send_rep();
			else if (pick < 85)
				repeat ($urandom_range(1, 4)) send_req(OP_SAMPLE, $urandom_range(0, cur_st));
			else if (pick < 97)
				send_req(OP_SAMPLE, $urandom_range(0, MaxSample));
			else
				send_req(OP_START, $urandom_range(0, MaxSample));
		end
		drain();
	endtask

	initial begin
		int st, et, reps, vlen, slen, pct, shorts, win;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Samples before the first start are ignored; thresholds are strict compares.
		send_req(OP_SAMPLE, MaxSample);
		send_req(OP_SAMPLE, 0);
		send_req(OP_START, 0);
		send_req(OP_SAMPLE, RstStartThr);
		send_req(OP_SAMPLE, RstStartThr + 1);
		send_req(OP_SAMPLE, MaxSample);
		send_req(OP_SAMPLE, RstEndThr);
		send_req(OP_SAMPLE, 0);
		send_req(OP_START, MaxSample);
		send_req(OP_SAMPLE, MaxSample);
		send_req(OP_SAMPLE, RstEndThr - 1);
		send_req(OP_SAMPLE, 12'h800);
		send_req(OP_SAMPLE, 12'hAAA);
		send_req(OP_SAMPLE, 12'h555);
		send_req(OP_SAMPLE, 50);
		send_req(OP_SAMPLE, MaxSample);
		send_req(OP_SAMPLE, MaxSample);
		send_req(OP_SAMPLE, 0);
		drain();

		// Extreme settings, each unable to declare a failure.
		configure(0, MaxSample, 0, 0, 0, 0, 0, 0, 1'b0);
		run_phase(40);
		configure(MaxSample, 0, 255, 65535, 65535, 100, 255, 65535, 1'b1);
		run_phase(40);
		configure(0, 0, 255, 65535, 0, 127, 0, 65535, 1'b1);
		run_phase(40);

		// Failure stays off here: while few requests have gone, the valid count cannot reach
		// 255, later both ratio and window are zero.
		for (int k = 0; k < 6; k++) begin
			st = $urandom_range(60, 3000);
			et = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MaxSample)
				: $urandom_range(1, st);
			vlen = $urandom_range(0, 12);
			slen = $urandom_range(0, 12);
			shorts = $urandom_range(0, 255);
			if (items_sent + 140 < 480) begin
				reps = 255;
				pct = $urandom_range(0, 127);
				win = $urandom_range(0, 65535);
			end else begin
				reps = $urandom_range(0, 255);
				pct = 0;
				win = 0;
			end
			configure(st, et, reps, vlen, slen, pct, shorts, win, $urandom_range(0, 3) == 0);
			run_phase(140);
		end

		// Last phase: failure is allowed and, being sticky, ends the analysis.
		st = $urandom_range(150, 2500);
		et = $urandom_range(20, st);
		vlen = $urandom_range(2, 8);
		slen = $urandom_range(vlen - 1, 10);
		win = $urandom_range(0, 1) ? 65535 : $urandom_range(20, 2000);
		configure(st, et, $urandom_range(0, 3), vlen, slen, $urandom_range(40, 127),
			$urandom_range(0, 4), win, 1'b0);
		run_phase(200);

		repeat (8) @(posedge clk);
		if (mismatches == 0 && due_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/efd_pkg.sv
sv/efd_cfg_regs.sv
sv/efd_core.sv
sv/emg_rep_fatigue_detector.sv
sim/efd_checker.sv
sim/tb.sv
